// ----- hdl/bmp24_stream_decoder_defines.svh -----
// assertion macros used by the bmp24 stream decoder
`ifndef BMP24_STREAM_DECODER_DEFINES_SVH
`define BMP24_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define BMP24_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define BMP24_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bmp24_pkg.sv -----
// types and constants of the 24-bit bmp stream decoder
package bmp24_pkg;

  // largest accepted image width and height
  localparam int unsigned MAX_DIM = 4096;
  // width of the dimension, row and column counters
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  // width of the row and column result fields
  localparam int unsigned COORD_W = 12;

  // header layout and expected values
  localparam int unsigned HDR_LEN = 54;
  localparam int unsigned INFO_LEN = 40;
  localparam int unsigned BPP_WANTED = 24;
  localparam logic [7:0] SIG_FIRST = 8'h42;
  localparam logic [7:0] SIG_SECOND = 8'h4D;

  // first byte index after the signature, and byte index at which each little-endian header field completes
  localparam logic [5:0] IDX_FIRST = 6'd2;
  localparam logic [5:0] IDX_PIX_OFFSET = 6'd13;
  localparam logic [5:0] IDX_INFO_SIZE = 6'd17;
  localparam logic [5:0] IDX_WIDTH = 6'd21;
  localparam logic [5:0] IDX_HEIGHT = 6'd25;
  localparam logic [5:0] IDX_PLANES_BPP = 6'd29;
  localparam logic [5:0] IDX_COMPRESSION = 6'd33;
  localparam logic [5:0] IDX_HEADER_END = 6'(HDR_LEN - 1);

  // decoder phase
  typedef enum logic [2:0] {
    PH_SIG0    = 3'd0,
    PH_SIG1    = 3'd1,
    PH_HEADER  = 3'd2,
    PH_SKIP    = 3'd3,
    PH_PIXEL   = 3'd4,
    PH_PAD     = 3'd5,
    PH_TAILPAD = 3'd6,
    PH_ERROR   = 3'd7
  } phase_t;

  // result kind
  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_BAD_SIG    = 2'd1,
    KIND_BAD_INFO   = 2'd2,
    KIND_BAD_FORMAT = 2'd3
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t               kind;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  column;
    logic                last_pixel;
  } result_t;

endpackage

// ----- hdl/bmp24_in_if.sv -----
// byte stream channel into the decoder
interface bmp24_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ----- hdl/bmp24_out_if.sv -----
// result channel out of the decoder
interface bmp24_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] row;
  logic [11:0] column;
  logic        last_pixel;

  modport source (output valid, output kind, output red, output green, output blue,
                  output row, output column, output last_pixel, input ready);
  modport sink (input valid, input kind, input red, input green, input blue,
                input row, input column, input last_pixel, output ready);
endinterface

// ----- hdl/bmp24_stream_decoder.sv -----
// Streaming decoder for 24-bit uncompressed BMP files: takes one file byte per
// cycle on stream while stream.ready is high and returns pixels (blue, green, red
// grouped, bottom row first, row padding dropped) or a single error item on
// result. Each byte is decoded by the phase registers and a short step of counter
// logic in the cycle it is accepted; its result, if any, goes to the result
// register, or to the one-item skid stage while the sink stalls, so stream.ready
// stays high while the sink stalls and falls only once both hold an item, so the
// sustained rate is one byte per cycle. After an error every byte is dropped until
// reset; after the last pixel and its row padding the block waits for a new file.
`include "bmp24_stream_decoder_defines.svh"

module bmp24_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  bmp24_in_if.sink     stream,
  bmp24_out_if.source  result
);

  // position of a byte inside one pixel
  localparam logic [1:0] BIP_BLUE  = 2'd0;
  localparam logic [1:0] BIP_GREEN = 2'd1;
  localparam logic [1:0] BIP_RED   = 2'd2;

  localparam int unsigned DW = bmp24_pkg::DIM_W;

  bmp24_pkg::phase_t  phase, phase_next;
  logic [5:0]         header_index, header_index_next;
  logic [31:0]        header_word, header_word_next;
  logic [DW-1:0]      image_width, image_width_next;
  logic [DW-1:0]      image_height, image_height_next;
  logic [31:0]        skip_count, skip_count_next;
  logic [15:0]        held_bytes, held_bytes_next;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next;
  logic [DW-1:0]      row_count, row_count_next;
  logic [DW-1:0]      column_count, column_count_next;
  logic [1:0]         pad_count, pad_count_next;

  logic               accept;
  logic               space;
  logic               res_push;
  bmp24_pkg::result_t res_data;

  logic [7:0]         b;
  logic [31:0]        hw_next;
  logic               dim_ok;
  logic               sig_ok;
  logic               info_ok;
  logic               fmt_ok;
  logic [DW-1:0]      col_inc;
  logic               row_end;
  logic [31:0]        skip_dec;
  logic [31:0]        pad_skip_next;

  assign accept       = stream.valid && stream.ready;
  assign stream.ready = space;
  assign b            = stream.data_byte;

  // shared decode terms
  assign hw_next  = {b, header_word[31:8]};
  assign dim_ok   = (hw_next != 32'd0) && (hw_next <= 32'(bmp24_pkg::MAX_DIM));
  assign sig_ok   = (held_bytes == {8'h00, bmp24_pkg::SIG_FIRST}) &&
                    (b == bmp24_pkg::SIG_SECOND);
  assign info_ok  = (hw_next == 32'(bmp24_pkg::INFO_LEN));
  assign fmt_ok   = (hw_next == 32'd0) && (held_bytes == 16'(bmp24_pkg::BPP_WANTED)) &&
                    (image_width != '0) && (image_height != '0) &&
                    (skip_count >= 32'(bmp24_pkg::HDR_LEN));
  assign col_inc  = column_count + DW'(1);
  assign row_end  = (col_inc >= image_width);
  assign skip_dec = skip_count - 32'd1;
  assign pad_skip_next = (skip_count != 32'd0) ? skip_dec : skip_count;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      bmp24_pkg::PH_SIG0: phase_next = bmp24_pkg::PH_SIG1;
      bmp24_pkg::PH_SIG1: begin
        phase_next = sig_ok ? bmp24_pkg::PH_HEADER : bmp24_pkg::PH_ERROR;
      end
      bmp24_pkg::PH_HEADER: begin
        if ((header_index == bmp24_pkg::IDX_INFO_SIZE) && !info_ok) begin
          phase_next = bmp24_pkg::PH_ERROR;
        end else if ((header_index == bmp24_pkg::IDX_COMPRESSION) && !fmt_ok) begin
          phase_next = bmp24_pkg::PH_ERROR;
        end else if (header_index == bmp24_pkg::IDX_HEADER_END) begin
          phase_next = (skip_count == 32'd0) ? bmp24_pkg::PH_PIXEL : bmp24_pkg::PH_SKIP;
        end
      end
      bmp24_pkg::PH_SKIP: begin
        if (skip_dec == 32'd0) phase_next = bmp24_pkg::PH_PIXEL;
      end
      bmp24_pkg::PH_PIXEL: begin
        if ((byte_in_pixel != BIP_BLUE) && (byte_in_pixel != BIP_GREEN) && row_end) begin
          if (row_count == '0) begin
            phase_next = (pad_count != 2'd0) ? bmp24_pkg::PH_TAILPAD : bmp24_pkg::PH_SIG0;
          end else if (pad_count != 2'd0) begin
            phase_next = bmp24_pkg::PH_PAD;
          end
        end
      end
      bmp24_pkg::PH_PAD: begin
        if (pad_skip_next == 32'd0) phase_next = bmp24_pkg::PH_PIXEL;
      end
      bmp24_pkg::PH_TAILPAD: begin
        if (pad_skip_next == 32'd0) phase_next = bmp24_pkg::PH_SIG0;
      end
      bmp24_pkg::PH_ERROR: phase_next = bmp24_pkg::PH_ERROR;
      default: phase_next = bmp24_pkg::PH_ERROR;
    endcase
  end

  // counters, header capture and result item
  always_comb begin
    header_index_next  = header_index;
    header_word_next   = header_word;
    image_width_next   = image_width;
    image_height_next  = image_height;
    skip_count_next    = skip_count;
    held_bytes_next    = held_bytes;
    byte_in_pixel_next = byte_in_pixel;
    row_count_next     = row_count;
    column_count_next  = column_count;
    pad_count_next     = pad_count;
    res_push           = 1'b0;
    res_data           = '0;
    unique case (phase)
      bmp24_pkg::PH_SIG0: held_bytes_next = {8'h00, b};
      bmp24_pkg::PH_SIG1: begin
        if (sig_ok) begin
          header_index_next = bmp24_pkg::IDX_FIRST;
          header_word_next  = '0;
        end else begin
          res_push      = 1'b1;
          res_data.kind = bmp24_pkg::KIND_BAD_SIG;
        end
      end
      bmp24_pkg::PH_HEADER: begin
        header_word_next  = hw_next;
        header_index_next = header_index + 6'd1;
        case (header_index)
          bmp24_pkg::IDX_PIX_OFFSET: skip_count_next = hw_next;
          bmp24_pkg::IDX_INFO_SIZE: begin
            if (!info_ok) begin
              res_push      = 1'b1;
              res_data.kind = bmp24_pkg::KIND_BAD_INFO;
            end
          end
          bmp24_pkg::IDX_WIDTH: image_width_next = dim_ok ? hw_next[DW-1:0] : '0;
          bmp24_pkg::IDX_HEIGHT: image_height_next = dim_ok ? hw_next[DW-1:0] : '0;
          bmp24_pkg::IDX_PLANES_BPP: held_bytes_next = hw_next[31:16];
          bmp24_pkg::IDX_COMPRESSION: begin
            if (!fmt_ok) begin
              res_push      = 1'b1;
              res_data.kind = bmp24_pkg::KIND_BAD_FORMAT;
            end else begin
              skip_count_next = skip_count - 32'(bmp24_pkg::HDR_LEN);
              // (4 - width*3 mod 4) mod 4 reduces to width mod 4
              pad_count_next  = image_width[1:0];
            end
          end
          bmp24_pkg::IDX_HEADER_END: begin
            if (skip_count == 32'd0) begin
              byte_in_pixel_next = BIP_BLUE;
              column_count_next  = '0;
              row_count_next     = image_height - DW'(1);
            end
          end
          default: ;
        endcase
      end
      bmp24_pkg::PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == 32'd0) begin
          byte_in_pixel_next = BIP_BLUE;
          column_count_next  = '0;
          row_count_next     = image_height - DW'(1);
        end
      end
      bmp24_pkg::PH_PIXEL: begin
        case (byte_in_pixel)
          BIP_BLUE: begin
            held_bytes_next    = {8'h00, b};
            byte_in_pixel_next = BIP_GREEN;
          end
          BIP_GREEN: begin
            held_bytes_next    = {b, held_bytes[7:0]};
            byte_in_pixel_next = BIP_RED;
          end
          default: begin
            // red byte completes the pixel
            byte_in_pixel_next  = BIP_BLUE;
            column_count_next   = row_end ? '0 : col_inc;
            if (row_end) begin
              skip_count_next = 32'(pad_count);
              if (row_count != '0) row_count_next = row_count - DW'(1);
            end
            res_push            = 1'b1;
            res_data.kind       = bmp24_pkg::KIND_PIXEL;
            res_data.red        = b;
            res_data.green      = held_bytes[15:8];
            res_data.blue       = held_bytes[7:0];
            res_data.row        = bmp24_pkg::COORD_W'(row_count);
            res_data.column     = bmp24_pkg::COORD_W'(column_count);
            res_data.last_pixel = row_end && (row_count == '0);
          end
        endcase
      end
      bmp24_pkg::PH_PAD, bmp24_pkg::PH_TAILPAD: skip_count_next = pad_skip_next;
      bmp24_pkg::PH_ERROR: ;
      default: ;
    endcase
  end

  // state registers, advanced once per accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bmp24_pkg::PH_SIG0;
      header_index  <= '0;
      header_word   <= '0;
      image_width   <= '0;
      image_height  <= '0;
      skip_count    <= '0;
      held_bytes    <= '0;
      byte_in_pixel <= BIP_BLUE;
      row_count     <= '0;
      column_count  <= '0;
      pad_count     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      header_index  <= header_index_next;
      header_word   <= header_word_next;
      image_width   <= image_width_next;
      image_height  <= image_height_next;
      skip_count    <= skip_count_next;
      held_bytes    <= held_bytes_next;
      byte_in_pixel <= byte_in_pixel_next;
      row_count     <= row_count_next;
      column_count  <= column_count_next;
      pad_count     <= pad_count_next;
    end
  end

  // result register and skid stage
  bmp24_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_push),
    .push_data (res_data),
    .space     (space),
    .result    (result)
  );

  // checks
  `BMP24_ASSERT_NEXT(a_error_sticks, phase == bmp24_pkg::PH_ERROR, phase == bmp24_pkg::PH_ERROR, "left error phase without reset")
  `BMP24_ASSERT_NOW(a_stall_needs_result, !stream.ready, result.valid, "input stalled with no result waiting")
  `BMP24_ASSERT_NEXT(a_pixel_emitted, accept && (phase == bmp24_pkg::PH_PIXEL) && (byte_in_pixel == BIP_RED), result.valid, "completed pixel not presented")
  `BMP24_ASSERT_NOW(a_last_on_top_row, result.valid && result.last_pixel, (result.row == 12'd0) && (result.kind == bmp24_pkg::KIND_PIXEL), "last pixel flag off the top row")

endmodule

// ----- hdl/bmp24_out_stage.sv -----
// result register with a skid stage, decoupling the decoder from the result sink
module bmp24_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bmp24_pkg::result_t push_data,
  output logic               space,
  bmp24_out_if.source        result
);

  logic               main_valid;
  bmp24_pkg::result_t main_data;
  logic               skid_valid;
  bmp24_pkg::result_t skid_data;
  logic               take;

  // an item leaves when the sink takes the result register
  assign take  = main_valid && result.ready;
  assign space = !skid_valid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload, refilled from the skid stage first
  always_ff @(posedge clk) begin
    if (!main_valid || take) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // drive the channel
  assign result.valid      = main_valid;
  assign result.kind       = main_data.kind;
  assign result.red        = main_data.red;
  assign result.green      = main_data.green;
  assign result.blue       = main_data.blue;
  assign result.row        = main_data.row;
  assign result.column     = main_data.column;
  assign result.last_pixel = main_data.last_pixel;

endmodule
